/* rtl/chained_hash_set_toggle_macros.svh */
// Assertion macros used by the top level of the hash set RTL.
`ifndef CHAINED_HASH_SET_TOGGLE_MACROS_SVH
`define CHAINED_HASH_SET_TOGGLE_MACROS_SVH

// Checked on every clock edge outside reset.
`define CHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/chs_pkg.sv */
// Types, constants and codes for the chained hash set.
package chs_pkg;

  localparam int BUCKETS   = 16;
  localparam int SLOTS     = 8;
  localparam int KEY_W     = 31;
  localparam int MOD_W     = 5;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int BKT_W     = 4;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int FILL_W    = $clog2(SLOTS + 1);
  localparam int ADDR_W    = BKT_W + SLOT_W;
  localparam int MEM_DEPTH = BUCKETS * SLOTS;
  localparam int CNT_W     = $clog2(KEY_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_TOGGLE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    POS_ZERO,
    POS_IDX,
    POS_FILL
  } pos_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND,
    S_DONE
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     idx_clr;
    logic     idx_inc;
    logic     scan_rd;
    logic     shift_rd;
    logic     shift_wr;
    logic     append;
    logic     fill_dec;
    logic     res_set;
    status_e  res_status;
    pos_sel_e res_pos;
    logic     out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              div_last;
    logic              is_insert;
    logic              is_toggle;
    logic              idx_end;
    logic              shift_end;
    logic              match;
    logic              full;
    logic              out_free;
    logic [FILL_W-1:0] fill_cur;
  } dp_stat_t;

endpackage

/* rtl/chs_in_if.sv */
// Input channel: command and key with valid/ready.
interface chs_in_if;
  logic                      valid;
  logic                      ready;
  logic [chs_pkg::CMD_W-1:0] cmd;
  logic [chs_pkg::KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

/* rtl/chs_out_if.sv */
// Result channel: status, bucket, position and fill with valid/ready.
interface chs_out_if;
  logic                         valid;
  logic                         ready;
  logic [chs_pkg::STATUS_W-1:0] status;
  logic [chs_pkg::BKT_W-1:0]    bucket;
  logic [chs_pkg::SLOT_W-1:0]   position;
  logic [chs_pkg::FILL_W-1:0]   fill;

  modport source (output valid, output status, output bucket, output position, output fill,
                  input ready);
  modport sink (input valid, input status, input bucket, input position, input fill,
                output ready);
endinterface

/* rtl/chs_ctrl.sv */
// Controller state machine sequencing hash, scan, compaction and append.
module chs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  chs_pkg::dp_stat_t stat_i,
  output chs_pkg::ctl_cmd_t cmd_o
);
  import chs_pkg::*;

  ctl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.res_status = ST_NOT_FOUND;
    cmd_o.res_pos    = POS_ZERO;
    in_ready_o       = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end

      // One remainder bit per cycle, key MSB first
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (stat_i.is_insert) begin
          state_d = S_APPEND;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end

      // Walk the chain from the oldest entry
      S_SCAN_RD: begin
        if (stat_i.idx_end) begin
          if (stat_i.is_toggle) begin
            state_d = S_APPEND;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_NOT_FOUND;
            cmd_o.res_pos    = POS_ZERO;
            state_d          = S_DONE;
          end
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (stat_i.match) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_pos = POS_IDX;
          if (stat_i.is_toggle) begin
            cmd_o.res_status = ST_REMOVED;
            state_d          = S_SHIFT_RD;
          end else begin
            cmd_o.res_status = ST_FOUND;
            state_d          = S_DONE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end

      // Close the gap: move each later entry down one slot
      S_SHIFT_RD: begin
        if (stat_i.shift_end) begin
          cmd_o.fill_dec = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_SHIFT_RD;
      end

      S_APPEND: begin
        cmd_o.res_set = 1'b1;
        if (stat_i.full) begin
          cmd_o.res_status = ST_FULL;
          cmd_o.res_pos    = POS_ZERO;
        end else begin
          cmd_o.append     = 1'b1;
          cmd_o.res_status = ST_INSERTED;
          cmd_o.res_pos    = POS_FILL;
        end
        state_d = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/chs_datapath.sv */
// Datapath: modulus register, serial remainder, chain memory, fill counts, result register.
module chs_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [chs_pkg::MOD_W-1:0]    cfg_wdata_i,
  input  logic [chs_pkg::CMD_W-1:0]    in_cmd_i,
  input  logic [chs_pkg::KEY_W-1:0]    in_key_i,
  input  chs_pkg::ctl_cmd_t            cmd_i,
  output chs_pkg::dp_stat_t            stat_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [chs_pkg::STATUS_W-1:0] out_status_o,
  output logic [chs_pkg::BKT_W-1:0]    out_bucket_o,
  output logic [chs_pkg::SLOT_W-1:0]   out_position_o,
  output logic [chs_pkg::FILL_W-1:0]   out_fill_o
);
  import chs_pkg::*;

  logic [MOD_W-1:0]  mod_q;
  logic [MOD_W-1:0]  eff_mod;
  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  div_sh_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [MOD_W-1:0]  rem_q;
  logic [MOD_W-1:0]  rem_sh;
  logic [MOD_W-1:0]  rem_d;
  logic [FILL_W-1:0] idx_q;
  logic [FILL_W-1:0] idx_nxt;
  logic [FILL_W-1:0] fill_q [BUCKETS];
  logic [FILL_W-1:0] fill_cur;
  logic [BKT_W-1:0]  bkt;
  logic [KEY_W-1:0]  mem_q [MEM_DEPTH];
  logic [KEY_W-1:0]  rd_data_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  status_e           status_q;
  logic [SLOT_W-1:0] pos_q;
  logic [SLOT_W-1:0] pos_d;
  logic              out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [BKT_W-1:0]  out_bucket_q;
  logic [SLOT_W-1:0] out_position_q;
  logic [FILL_W-1:0] out_fill_q;

  // Modulus clamped to 1..BUCKETS
  always_comb begin
    if (mod_q == '0) begin
      eff_mod = MOD_W'(1);
    end else if (mod_q > MOD_W'(BUCKETS)) begin
      eff_mod = MOD_W'(BUCKETS);
    end else begin
      eff_mod = mod_q;
    end
  end

  // Restoring remainder step; remainder stays below the modulus
  always_comb begin
    rem_sh = {rem_q[MOD_W-2:0], div_sh_q[KEY_W-1]};
    if (rem_sh >= eff_mod) begin
      rem_d = rem_sh - eff_mod;
    end else begin
      rem_d = rem_sh;
    end
  end

  assign bkt      = rem_q[BKT_W-1:0];
  assign fill_cur = fill_q[bkt];
  assign idx_nxt  = idx_q + FILL_W'(1);

  // Status toward the controller
  always_comb begin
    stat_o.div_last  = (cnt_q == '0);
    stat_o.is_insert = (cmd_q == CMD_INSERT);
    stat_o.is_toggle = (cmd_q == CMD_TOGGLE);
    stat_o.idx_end   = (idx_q >= fill_cur);
    stat_o.shift_end = (idx_nxt >= fill_cur);
    stat_o.match     = (rd_data_q == key_q);
    stat_o.full      = (fill_cur >= FILL_W'(SLOTS));
    stat_o.out_free  = !out_valid_q || out_ready_i;
    stat_o.fill_cur  = fill_cur;
  end

  // Memory port selection
  always_comb begin
    rd_en   = cmd_i.scan_rd || cmd_i.shift_rd;
    rd_addr = cmd_i.shift_rd ? {bkt, idx_nxt[SLOT_W-1:0]} : {bkt, idx_q[SLOT_W-1:0]};
    wr_en   = cmd_i.shift_wr || cmd_i.append;
    wr_addr = cmd_i.append ? {bkt, fill_cur[SLOT_W-1:0]} : {bkt, idx_q[SLOT_W-1:0]};
    wr_data = cmd_i.append ? key_q : rd_data_q;
  end

  // Chain memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Result position select
  always_comb begin
    case (cmd_i.res_pos)
      POS_IDX:  pos_d = idx_q[SLOT_W-1:0];
      POS_FILL: pos_d = fill_cur[SLOT_W-1:0];
      default:  pos_d = '0;
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= MOD_W'(BUCKETS);
      cnt_q       <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        cnt_q <= CNT_W'(KEY_W - 1);
        rem_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
        rem_q <= rem_d;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_nxt;
      end
      if (cmd_i.append) begin
        fill_q[bkt] <= fill_cur + FILL_W'(1);
      end else if (cmd_i.fill_dec) begin
        fill_q[bkt] <= fill_cur - FILL_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= in_cmd_i;
      key_q    <= in_key_i;
      div_sh_q <= in_key_i;
    end else if (cmd_i.div_step) begin
      div_sh_q <= {div_sh_q[KEY_W-2:0], 1'b0};
    end
    if (cmd_i.res_set) begin
      status_q <= cmd_i.res_status;
      pos_q    <= pos_d;
    end
    if (cmd_i.out_load) begin
      out_status_q   <= status_q;
      out_bucket_q   <= bkt;
      out_position_q <= pos_q;
      out_fill_q     <= fill_cur;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_bucket_o   = out_bucket_q;
  assign out_position_o = out_position_q;
  assign out_fill_o     = out_fill_q;

endmodule

/* rtl/chained_hash_set_toggle.sv */
// Top level of the chained hash set with insert, toggle and lookup.
//
//   Port          Dir   Content
//   in_i          sink  cmd, key (valid/ready)
//   out_o         src   status, bucket, position, fill (valid/ready)
//   cfg_we_i/...  in    modulus write (5 bits)
//
// An item takes a bit-serial remainder by the modulus, then a read and a compare per
// chain slot scanned and a read and a write per entry moved down on a removal, over one
// memory port with a registered read.
// Reset clears the fill counts and sets the modulus to 16; chain slots need no clearing.
// A new item is taken as soon as the controller is idle, even while a result waits
// in the output register; the controller stalls only if that register is still full.
module chained_hash_set_toggle (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [chs_pkg::MOD_W-1:0] cfg_wdata_i,
  chs_in_if.sink                    in_i,
  chs_out_if.source                 out_o
);
  import chs_pkg::*;
  `include "chained_hash_set_toggle_macros.svh"

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  chs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  chs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_cmd_i       (in_i.cmd),
    .in_key_i       (in_i.key),
    .cmd_i          (ctl_cmd),
    .stat_o         (dp_stat),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_status_o   (out_o.status),
    .out_bucket_o   (out_o.bucket),
    .out_position_o (out_o.position),
    .out_fill_o     (out_o.fill)
  );

  // Chain length of the addressed bucket never exceeds the slot count
  `CHS_ASSERT(a_fill_bound, dp_stat.fill_cur <= FILL_W'(SLOTS), "bucket fill above slot count")

  // A dropped insert only happens on a full bucket
  `CHS_ASSERT(a_full_fill,
              (out_o.valid && out_o.status == ST_FULL) |-> (out_o.fill == FILL_W'(SLOTS)),
              "full status on a bucket with room")

  // Found or inserted keys sit inside the chain
  `CHS_ASSERT(a_pos_in_chain,
              (out_o.valid && (out_o.status == ST_FOUND || out_o.status == ST_INSERTED))
                |-> (FILL_W'(out_o.position) < out_o.fill),
              "position outside chain")

  // One item at a time: after an accept the input side is closed
  `CHS_ASSERT(a_single_item, (in_i.valid && in_i.ready) |=> !in_i.ready, "input accepted while busy")

  // Nothing is reported out of reset
  `CHS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_o.valid, "result valid during reset")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the chained hash set: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import chs_pkg::*;

  // One result item as the block reports it
  typedef struct packed {
    status_e             status;
    logic [BKT_W-1:0]    bucket;
    logic [SLOT_W-1:0]   position;
    logic [FILL_W-1:0]   fill;
  } hash_result_t;

  // One row of the directed table; res is used only where typed is set
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic             typed;
    hash_result_t     res;
  } dir_row_t;

  localparam logic [CMD_W-1:0] CMD_SPARE    = 2'd3;  // unused code, decodes as lookup
  localparam logic [KEY_W-1:0] KEY_MAX      = 31'h7FFF_FFFF;
  localparam int               ROWS         = 24;
  localparam int               PHASES       = 8;
  localparam int               PHASE_ITEMS  = 230;
  localparam int               POOL_SIZE    = 24;
  localparam int               HOLD_CYCLES  = 400;
  localparam int               HOLD_AT      = 500;
  localparam int               DRAIN_CYCLES = 60;
  localparam int               LIMIT_CYCLES = 3000;
  localparam hash_result_t     NO_RES       = '0;

  localparam dir_row_t DIR_ROWS [ROWS] = '{
    '{CMD_LOOKUP, 31'd0,       1'b1, '{ST_NOT_FOUND, 4'd0,  3'd0, 4'd0}},
    '{CMD_INSERT, KEY_MAX,     1'b1, '{ST_INSERTED,  4'd15, 3'd0, 4'd1}},
    '{CMD_TOGGLE, KEY_MAX,     1'b1, '{ST_REMOVED,   4'd15, 3'd0, 4'd0}},
    // fill bucket 3, duplicate key 3 kept
    '{CMD_INSERT, 31'd3,       1'b0, NO_RES},
    '{CMD_INSERT, 31'd19,      1'b0, NO_RES},
    '{CMD_INSERT, 31'd35,      1'b0, NO_RES},
    '{CMD_INSERT, 31'd3,       1'b0, NO_RES},
    '{CMD_INSERT, 31'd51,      1'b0, NO_RES},
    '{CMD_INSERT, 31'd67,      1'b0, NO_RES},
    '{CMD_INSERT, 31'd83,      1'b0, NO_RES},
    '{CMD_INSERT, 31'd99,      1'b0, NO_RES},
    // full bucket: insert and unmatched toggle are dropped
    '{CMD_INSERT, 31'd131,     1'b1, '{ST_FULL,      4'd3,  3'd0, 4'd8}},
    '{CMD_TOGGLE, 31'd147,     1'b1, '{ST_FULL,      4'd3,  3'd0, 4'd8}},
    '{CMD_LOOKUP, 31'd3,       1'b0, NO_RES},
    // remove from a full bucket, duplicate moves down
    '{CMD_TOGGLE, 31'd3,       1'b0, NO_RES},
    '{CMD_LOOKUP, 31'd3,       1'b0, NO_RES},
    '{CMD_TOGGLE, 31'd99,      1'b0, NO_RES},
    '{CMD_TOGGLE, 31'd99,      1'b0, NO_RES},
    '{CMD_SPARE,  31'd19,      1'b0, NO_RES},
    '{CMD_LOOKUP, KEY_MAX,     1'b1, '{ST_NOT_FOUND, 4'd15, 3'd0, 4'd0}},
    '{CMD_INSERT, 31'd0,       1'b1, '{ST_INSERTED,  4'd0,  3'd0, 4'd1}},
    '{CMD_TOGGLE, 31'h4000_0000, 1'b0, NO_RES},
    '{CMD_LOOKUP, 31'h2AAA_AAAA, 1'b0, NO_RES},
    '{CMD_LOOKUP, 31'h5555_5555, 1'b0, NO_RES}
  };

  // Modulus settings per random phase, out-of-range values included
  localparam logic [MOD_W-1:0] MOD_PLAN [PHASES] = '{
    5'd1, 5'd0, 5'd31, 5'd7, 5'd17, 5'd2, 5'd16, 5'd11
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [MOD_W-1:0] cfg_wdata;

  chs_in_if  in_if ();
  chs_out_if out_if ();

  chained_hash_set_toggle u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Shadow copy of the table
  logic [KEY_W-1:0] chain_key [BUCKETS][SLOTS];
  int               chain_len [BUCKETS];
  logic [MOD_W-1:0] mod_setting;

  hash_result_t     pending_results [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               mismatches;
  int               idle_cycles;
  int               results_seen;
  int               items_sent;
  bit               send_quiet;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one command to the shadow table and return its result
  function automatic hash_result_t hash_set_apply(logic [CMD_W-1:0] cmd,
                                                  logic [KEY_W-1:0] key);
    int unsigned  m;
    int unsigned  b;
    int           hit;
    int           i;
    hash_result_t r;
    m = mod_setting;
    if (m == 0) m = 1;
    if (m > BUCKETS) m = BUCKETS;
    b = key % m;
    hit = -1;
    r = NO_RES;
    r.bucket = BKT_W'(b);
    if (cmd != CMD_INSERT) begin
      for (i = 0; i < chain_len[b]; i++) begin
        if (hit < 0 && chain_key[b][i] == key) hit = i;
      end
    end
    if (cmd == CMD_INSERT || (cmd == CMD_TOGGLE && hit < 0)) begin
      if (chain_len[b] < SLOTS) begin
        chain_key[b][chain_len[b]] = key;
        r.position = SLOT_W'(chain_len[b]);
        chain_len[b]++;
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_FULL;
      end
    end else if (cmd == CMD_TOGGLE) begin
      // close the gap, order kept
      for (i = hit; i + 1 < chain_len[b]; i++) chain_key[b][i] = chain_key[b][i + 1];
      chain_len[b]--;
      r.status = ST_REMOVED;
      r.position = SLOT_W'(hit);
    end else if (hit >= 0) begin
      r.status = ST_FOUND;
      r.position = SLOT_W'(hit);
    end else begin
      r.status = ST_NOT_FOUND;
    end
    r.fill = FILL_W'(chain_len[b]);
    return r;
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Offer one item after a random gap; valid stays high after acceptance
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                           logic typed, hash_result_t typed_res);
    int           gap;
    hash_result_t res;
    if (items_sent % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    gap = send_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.key   <= key;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = hash_set_apply(cmd, key);
    pending_results.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // Drop valid and let every outstanding result come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [MOD_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    mod_setting = value;
  endtask

  // Random command mix over a key pool so chains fill, hit and empty
  task automatic run_phase(logic [MOD_W-1:0] value);
    int               n;
    int               pick;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    write_modulus(value);
    for (n = 0; n < POOL_SIZE; n++) begin
      key_pool[n] = (n % 2 == 0) ? KEY_W'($urandom_range(0, 63)) : KEY_W'($urandom());
    end
    for (n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      cmd = CMD_INSERT;
      else if (pick < 70) cmd = CMD_TOGGLE;
      else if (pick < 95) cmd = CMD_LOOKUP;
      else                cmd = CMD_SPARE;
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else                            key = KEY_W'($urandom());
      send_item(cmd, key, 1'b0, NO_RES);
    end
  endtask

  // Stimulus and end of run
  initial begin
    int row;
    int ph;
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.cmd    <= '0;
    in_if.key    <= '0;
    mismatches   = 0;
    items_sent   = 0;
    send_quiet   = 1'b0;
    mod_setting  = 5'd16;
    for (int b = 0; b < BUCKETS; b++) chain_len[b] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < ROWS; row++) begin
      send_item(DIR_ROWS[row].cmd, DIR_ROWS[row].key, DIR_ROWS[row].typed,
                DIR_ROWS[row].res);
    end
    for (ph = 0; ph < PHASES; ph++) run_phase(MOD_PLAN[ph]);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the input
  initial begin
    int           stall;
    bit           quiet;
    hash_result_t exp_res;
    out_if.ready <= 1'b0;
    results_seen = 0;
    quiet        = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (results_seen % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item outstanding, status %0d bucket %0d",
                 $time, out_if.status, out_if.bucket);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status",   exp_res.status,   out_if.status);
        check_field("bucket",   exp_res.bucket,   out_if.bucket);
        check_field("position", exp_res.position, out_if.position);
        check_field("fill",     exp_res.fill,     out_if.fill);
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= LIMIT_CYCLES) begin
      $display("%0t: no progress for %0d cycles", $time, LIMIT_CYCLES);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/chs_pkg.sv
rtl/chs_in_if.sv
rtl/chs_out_if.sv
rtl/chs_ctrl.sv
rtl/chs_datapath.sv
rtl/chained_hash_set_toggle.sv
tb/tb_top.sv
